[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/umi_pkg.sv]
// Types, constants and helper functions of the unicycle motion integrator
package umi_pkg;

    // datapath widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NET_W   = 49;
    localparam int PART_W  = 58;
    localparam int ACC_W   = 50;
    localparam int SUM_W   = 51;
    localparam int CORD_W  = 34;
    localparam int ANGLE_W = 33;
    localparam int ATAN_IDX_W = 5;
    localparam int CFG_INDEX_W = 3;

    // CORDIC start vector, gain 0.60725293 in Q4.30
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INVERSE_MASS,
        CFG_COULOMB,
        CFG_VISCOUS,
        CFG_INIT_X,
        CFG_INIT_Y,
        CFG_INIT_HEADING
    } umi_cfg_index_t;

    typedef struct packed {
        logic [23:0]        inverse_mass;
        logic [30:0]        coulomb_friction;
        logic [30:0]        viscous_coefficient;
        logic signed [31:0] initial_x;
        logic signed [31:0] initial_y;
        logic [31:0]        initial_heading;
    } umi_cfg_t;

    typedef struct packed {
        logic               restart;
        logic [15:0]        delta_time;
        logic signed [31:0] drive_force;
        logic signed [31:0] turn_rate;
    } umi_item_t;

    // first field in the highest bits
    typedef struct packed {
        logic [31:0]        heading;
        logic signed [31:0] speed;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } umi_result_t;

    typedef struct packed {
        logic               busy;
        logic signed [31:0] cos_val;
        logic signed [31:0] sin_val;
    } umi_trig_t;

    // arctangent of 2^-i in turns, 2^32 per turn
    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h2000_0000;
            5'd1:    r = 32'h12E4_051E;
            5'd2:    r = 32'h09FB_385B;
            5'd3:    r = 32'h0511_11D4;
            5'd4:    r = 32'h028B_0D43;
            5'd5:    r = 32'h0145_D7E1;
            5'd6:    r = 32'h00A2_F61E;
            5'd7:    r = 32'h0051_7C55;
            5'd8:    r = 32'h0028_BE53;
            5'd9:    r = 32'h0014_5F2F;
            5'd10:   r = 32'h000A_2F98;
            5'd11:   r = 32'h0005_17CC;
            5'd12:   r = 32'h0002_8BE6;
            5'd13:   r = 32'h0001_45F3;
            5'd14:   r = 32'h0000_A2FA;
            5'd15:   r = 32'h0000_517D;
            5'd16:   r = 32'h0000_28BE;
            5'd17:   r = 32'h0000_145F;
            5'd18:   r = 32'h0000_0A30;
            5'd19:   r = 32'h0000_0518;
            5'd20:   r = 32'h0000_028C;
            5'd21:   r = 32'h0000_0146;
            5'd22:   r = 32'h0000_00A3;
            5'd23:   r = 32'h0000_0051;
            5'd24:   r = 32'h0000_0029;
            5'd25:   r = 32'h0000_0014;
            5'd26:   r = 32'h0000_000A;
            5'd27:   r = 32'h0000_0005;
            5'd28:   r = 32'h0000_0003;
            5'd29:   r = 32'h0000_0001;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

    // clamp to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31]))
            r = v[31:0];
        else if (v[SUM_W-1])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

endpackage

[rtl/umi_cordic.sv]
// Iterative rotation CORDIC: cosine and sine of a heading, one iteration per cycle
`include "assert_macros.svh"

module umi_cordic
    import umi_pkg::*;
#(
    parameter int ITERATIONS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] angle,
    output umi_trig_t   trig
);

    localparam int ITER_W = $clog2(ITERATIONS);
    localparam logic [ITER_W-1:0] LAST = ITER_W'(ITERATIONS - 1);

    logic                     busy_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic signed [CORD_W-1:0] x_reg;
    logic signed [CORD_W-1:0] y_reg;
    logic signed [ANGLE_W-1:0] z_reg;
    logic [1:0]               quad_reg;

    logic [31:0]               biased;
    logic [1:0]                quad_next;
    logic [31:0]               resid;
    logic signed [CORD_W-1:0]  x_shift;
    logic signed [CORD_W-1:0]  y_shift;
    logic signed [ANGLE_W-1:0] atan_s;
    logic signed [CORD_W-1:0]  x_neg;
    logic signed [CORD_W-1:0]  y_neg;

    assign biased    = angle + 32'h2000_0000;
    assign quad_next = biased[31:30];
    assign resid     = angle - {quad_next, 30'd0};

    // shared shifter and adders
    assign x_shift = x_reg >>> iter_reg;
    assign y_shift = y_reg >>> iter_reg;
    assign atan_s  = ANGLE_W'(atan_turn(ATAN_IDX_W'(iter_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (iter_reg == LAST)
                busy_reg <= 1'b0;
            else
                iter_reg <= iter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= ANGLE_W'(signed'(resid));
            quad_reg <= quad_next;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ANGLE_W-1])
            begin
                x_reg <= x_reg - y_shift;
                y_reg <= y_reg + x_shift;
                z_reg <= z_reg - atan_s;
            end
            else
            begin
                x_reg <= x_reg + y_shift;
                y_reg <= y_reg - x_shift;
                z_reg <= z_reg + atan_s;
            end
        end
    end

    // quadrant correction
    assign x_neg = -x_reg;
    assign y_neg = -y_reg;

    always_comb
    begin
        trig.busy = busy_reg;
        case (quad_reg)
            2'd0:
            begin
                trig.cos_val = x_reg[31:0];
                trig.sin_val = y_reg[31:0];
            end
            2'd1:
            begin
                trig.cos_val = y_neg[31:0];
                trig.sin_val = x_reg[31:0];
            end
            2'd2:
            begin
                trig.cos_val = x_neg[31:0];
                trig.sin_val = y_neg[31:0];
            end
            default:
            begin
                trig.cos_val = y_reg[31:0];
                trig.sin_val = x_neg[31:0];
            end
        endcase
    end

    `ASSERT_IMPL(a_start_when_idle, clk, rst_n, start, !busy_reg)
    `ASSERT_NEXT(a_start_loads, clk, rst_n, start, busy_reg && (iter_reg == '0))

endmodule

[rtl/umi_core.sv]
// Step sequencer with one shared multiplier: speed, heading and position update
module umi_core
    import umi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  umi_item_t   item,
    input  umi_cfg_t    cfg,
    input  umi_trig_t   trig,
    output logic        trig_start,
    output logic [31:0] trig_angle,
    output logic        ready,
    output logic        done,
    input  logic        take,
    output umi_result_t result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_VB,
        S_NET,
        S_HI,
        S_LO,
        S_RATE,
        S_AH,
        S_AL,
        S_V,
        S_WAIT,
        S_VC,
        S_PC,
        S_VS,
        S_PS,
        S_Y,
        S_DONE
    } state_t;

    state_t state_reg;

    // architectural state
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] v_reg;
    logic [31:0]        h_reg;

    // working registers
    umi_item_t                item_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [NET_W-1:0]  net_reg;
    logic signed [PART_W-1:0] part_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [31:0]       vn_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  product;
    logic signed [MUL_B_W-1:0] dt_b;
    logic signed [MUL_B_W-1:0] inv_b;
    logic signed [31:0]        force_s;
    logic signed [31:0]        rate_s;
    logic signed [31:0]        cos_s;
    logic signed [31:0]        sin_s;
    logic signed [NET_W-1:0]   vb_scaled;
    logic signed [NET_W-1:0]   force_w;
    logic signed [NET_W-1:0]   mu_w;
    logic signed [NET_W-1:0]   net_next;
    logic signed [PART_W-1:0]  acc_sum;
    logic signed [SUM_W-1:0]   prod_scaled;
    logic signed [SUM_W-1:0]   v_sum;
    logic signed [SUM_W-1:0]   x_sum;
    logic signed [SUM_W-1:0]   y_sum;

    assign force_s = item_reg.drive_force;
    assign rate_s  = item_reg.turn_rate;
    assign cos_s   = trig.cos_val;
    assign sin_s   = trig.sin_val;
    assign dt_b    = MUL_B_W'({1'b0, item_reg.delta_time});
    assign inv_b   = MUL_B_W'({1'b0, cfg.inverse_mass});

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_VB:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = MUL_B_W'({1'b0, cfg.viscous_coefficient});
            end
            S_HI:
            begin
                mul_a = MUL_A_W'(net_reg >>> 16);
                mul_b = inv_b;
            end
            S_LO:
            begin
                mul_a = MUL_A_W'({1'b0, net_reg[15:0]});
                mul_b = inv_b;
            end
            S_RATE:
            begin
                mul_a = MUL_A_W'(rate_s);
                mul_b = dt_b;
            end
            S_AH:
            begin
                mul_a = acc_reg[ACC_W-1:16];
                mul_b = dt_b;
            end
            S_AL:
            begin
                mul_a = MUL_A_W'({1'b0, acc_reg[15:0]});
                mul_b = dt_b;
            end
            S_VC:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = MUL_B_W'(cos_s);
            end
            S_VS:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = MUL_B_W'(sin_s);
            end
            S_PC, S_PS:
            begin
                mul_a = MUL_A_W'(prod_reg >>> 30);
                mul_b = dt_b;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // net force: drive minus viscous drag minus Coulomb friction against motion
    assign vb_scaled = NET_W'(prod_reg >>> 16);
    assign force_w   = NET_W'(force_s);
    assign mu_w      = NET_W'({1'b0, cfg.coulomb_friction});

    always_comb
    begin
        if (v_reg > 0)
            net_next = force_w - vb_scaled - mu_w;
        else if (v_reg < 0)
            net_next = force_w - vb_scaled + mu_w;
        else
            net_next = force_w - vb_scaled;
    end

    // hi*inv plus (lo*inv >> 16), then >> 8
    assign acc_sum     = part_reg + PART_W'(prod_reg >>> 16);
    assign prod_scaled = SUM_W'(prod_reg >>> 16);
    assign v_sum       = SUM_W'(v_reg) + SUM_W'(part_reg) + prod_scaled;
    assign x_sum       = SUM_W'(x_reg) + prod_scaled;
    assign y_sum       = SUM_W'(y_reg) + prod_scaled;

    assign trig_start = (state_reg == S_IDLE) && start && !item.restart;
    assign trig_angle = h_reg;
    assign ready      = (state_reg == S_IDLE);
    assign done       = (state_reg == S_DONE);

    assign result.pos_x   = x_reg;
    assign result.pos_y   = y_reg;
    assign result.speed   = v_reg;
    assign result.heading = h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            v_reg     <= '0;
            h_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (item.restart)
                        begin
                            x_reg     <= cfg.initial_x;
                            y_reg     <= cfg.initial_y;
                            v_reg     <= '0;
                            h_reg     <= cfg.initial_heading;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_VB;
                    end
                end
                S_VB:   state_reg <= S_NET;
                S_NET:  state_reg <= S_HI;
                S_HI:   state_reg <= S_LO;
                S_LO:   state_reg <= S_RATE;
                S_RATE: state_reg <= S_AH;
                S_AH:
                begin
                    h_reg     <= h_reg + prod_reg[39:8];
                    state_reg <= S_AL;
                end
                S_AL:   state_reg <= S_V;
                S_V:    state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (!trig.busy)
                        state_reg <= S_VC;
                end
                S_VC:   state_reg <= S_PC;
                S_PC:   state_reg <= S_VS;
                S_VS:
                begin
                    x_reg     <= sat32(x_sum);
                    state_reg <= S_PS;
                end
                S_PS:   state_reg <= S_Y;
                S_Y:
                begin
                    y_reg     <= sat32(y_sum);
                    v_reg     <= vn_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (take)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= product;
        if (state_reg == S_IDLE && start)
            item_reg <= item;
        if (state_reg == S_NET)
            net_reg <= net_next;
        if (state_reg == S_LO)
            part_reg <= PART_W'(prod_reg);
        if (state_reg == S_RATE)
            acc_reg <= acc_sum[PART_W-1:8];
        if (state_reg == S_AL)
            part_reg <= PART_W'(prod_reg);
        if (state_reg == S_V)
            vn_reg <= sat32(v_sum);
    end

endmodule

[rtl/unicycle_motion_integrator_top.sv]
// Top level of the unicycle motion integrator: ports, registers, result buffer
//
// One input word is one forward Euler step of a unicycle vehicle (or a restart).
// s_axis: restart in tuser, time step, drive force and turn rate in tdata.
// m_axis: the new pose and speed after every input word, one result per word.
// cfg: write channel for inverse mass, friction, drag and the restart pose;
// cfg_ready is always high, writes are meant for idle periods only.
// Sequence: a step word is taken while the sequencer is idle and starts the
// CORDIC. The speed and heading updates share one multiplier and overlap the
// CORDIC, which runs one iteration per cycle; the sequencer then waits for it,
// and the four position products follow before the result goes to the output
// register. A restart word loads the restart pose and goes straight to done.
// The next word is taken only once the sequencer is back in idle.
// s_axis_tready is high only while the sequencer is idle.
// Reset clears position, speed and heading and loads register defaults
// (inverse mass 16777, all else zero).
// A stalled m_axis holds its word in the output register; the next input
// is still taken and computed, then waits in the sequencer until the
// output register frees up.
`include "assert_macros.svh"

module unicycle_motion_integrator_top
    import umi_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [79:0]            s_axis_tdata,  // delta_time, drive_force, turn_rate
    input  logic                   s_axis_tuser,  // restart
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [127:0]           m_axis_tdata,  // pos_x, pos_y, speed, heading
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam logic [23:0] INV_MASS_RESET = 24'd16777;

    umi_cfg_t    cfg_reg;
    umi_item_t   item;
    umi_trig_t   trig;
    umi_result_t core_result;
    umi_result_t out_data_reg;
    logic        out_valid_reg;
    logic        core_ready;
    logic        core_done;
    logic        core_take;
    logic        trig_start;
    logic [31:0] trig_angle;
    logic        in_fire;

    // register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inverse_mass        <= INV_MASS_RESET;
            cfg_reg.coulomb_friction    <= '0;
            cfg_reg.viscous_coefficient <= '0;
            cfg_reg.initial_x           <= '0;
            cfg_reg.initial_y           <= '0;
            cfg_reg.initial_heading     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INVERSE_MASS: cfg_reg.inverse_mass        <= cfg_data[23:0];
                CFG_COULOMB:      cfg_reg.coulomb_friction    <= cfg_data[30:0];
                CFG_VISCOUS:      cfg_reg.viscous_coefficient <= cfg_data[30:0];
                CFG_INIT_X:       cfg_reg.initial_x           <= cfg_data;
                CFG_INIT_Y:       cfg_reg.initial_y           <= cfg_data;
                CFG_INIT_HEADING: cfg_reg.initial_heading     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // unpack the input word
    assign item.restart     = s_axis_tuser;
    assign item.delta_time  = s_axis_tdata[15:0];
    assign item.drive_force = s_axis_tdata[47:16];
    assign item.turn_rate   = s_axis_tdata[79:48];

    assign s_axis_tready = core_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    umi_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (trig_angle),
        .trig  (trig)
    );

    umi_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_fire),
        .item       (item),
        .cfg        (cfg_reg),
        .trig       (trig),
        .trig_start (trig_start),
        .trig_angle (trig_angle),
        .ready      (core_ready),
        .done       (core_done),
        .take       (core_take),
        .result     (core_result)
    );

    // output register: loads when empty or being drained
    assign core_take = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_done && core_take)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_done && core_take)
            out_data_reg <= core_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !s_axis_tready)
    `ASSERT_NEXT(a_result_kept, clk, rst_n, core_done && out_valid_reg && !m_axis_tready, core_done)

endmodule
